// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define MSOT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("msot assertion failed");

// checked also while reset is high
`define MSOT_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("msot assertion failed");

`endif

// ===== hdl/msot_pkg.sv =====
package msot_pkg;

   localparam int DEF_NUM_SLOTS = 16;
   localparam int MAX_SLOTS     = 16;

   localparam int ACTION_W = 2;
   localparam int DUR_W    = 32;
   localparam int SLOT_W   = 4;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMAIN = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOFREE  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd3;

   localparam logic [DUR_W-1:0] MIN_DUR_RESET = 32'd1;

   // slot ids are 4 bits, so the bank never exceeds MAX_SLOTS
   function automatic int slot_count_f(input int n);
      int c;
      c = (n > MAX_SLOTS) ? MAX_SLOTS : ((n < 1) ? 1 : n);
      return c;
   endfunction

   typedef struct packed {
      logic capture;
      logic apply_op;
      logic apply_tick;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic fire_any;
      logic fire_last;
   } dp_status_type;

endpackage

// ===== hdl/msot_req_if.sv =====
interface msot_req_if import msot_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [DUR_W-1:0]    duration;
   logic [SLOT_W-1:0]   slot_id;

   modport source (output valid, action, duration, slot_id, input ready);
   modport sink   (input valid, action, duration, slot_id, output ready);
endinterface

// ===== hdl/msot_rsp_if.sv =====
interface msot_rsp_if import msot_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_out;
   logic [DUR_W-1:0]    remaining;
   logic                any_active;
   logic                last;

   modport source (output valid, kind, status, slot_out, remaining, any_active, last,
                   input ready);
   modport sink   (input valid, kind, status, slot_out, remaining, any_active, last,
                   output ready);
endinterface

// ===== hdl/multi_slot_oneshot_timer.sv =====
// Start, cancel and query: the input word is captured, then its result word is
// registered once the output is free; no new word is taken before that.
// Tick: all active slots count down together, then one expiry word per cycle
// while the output is not stalled.
// Reset: all slots inactive, min_duration = 1, no result word pending.
module multi_slot_oneshot_timer import msot_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DUR_W-1:0]  csr_wr_data,
   msot_req_if.sink          req_chan,
   msot_rsp_if.source        rsp_chan
);

   localparam int SLOT_COUNT = slot_count_f(NUM_SLOTS);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   msot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msot_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_action     (req_chan.action),
      .req_duration   (req_chan.duration),
      .req_slot_id    (req_chan.slot_id),
      .cmd            (cmd),
      .status         (status),
      .rsp_kind       (rsp_chan.kind),
      .rsp_status     (rsp_chan.status),
      .rsp_slot_out   (rsp_chan.slot_out),
      .rsp_remaining  (rsp_chan.remaining),
      .rsp_any_active (rsp_chan.any_active),
      .rsp_last       (rsp_chan.last)
   );

endmodule

// ===== hdl/msot_ctrl.sv =====
module msot_ctrl import msot_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.is_tick) begin
               cmd.apply_tick = 1'b1;
               state_in       = S_EMIT;
            end else if (out_free) begin
               cmd.apply_op = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!status.fire_any) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               if (status.fire_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.apply_op || cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/msot_datapath.sv =====
module msot_datapath import msot_pkg::*; #(
   parameter int SLOT_COUNT = DEF_NUM_SLOTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [DUR_W-1:0]    csr_wr_data,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [DUR_W-1:0]    req_duration,
   input  logic [SLOT_W-1:0]   req_slot_id,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic [DUR_W-1:0]    rsp_remaining,
   output logic                rsp_any_active,
   output logic                rsp_last
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W+1)'(SLOT_COUNT);

   logic [ACTION_W-1:0] act_ff;
   logic [DUR_W-1:0]    dur_ff;
   logic [SLOT_W-1:0]   sid_ff;
   logic [DUR_W-1:0]    min_dur_ff;

   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [SLOT_COUNT-1:0] fired_ff, fired_in;
   logic [DUR_W-1:0]      rem_ff [SLOT_COUNT];
   logic [DUR_W-1:0]      rem_in [SLOT_COUNT];

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [DUR_W-1:0]    remo_ff, remo_in;
   logic                any_ff, any_in;
   logic                last_ff, last_in;

   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] fire_idx;
   logic [IDX_W-1:0] sid_idx;
   logic             sid_in_range;
   logic             sid_ok;
   logic             too_short;
   logic             start_ok;

   assign sid_idx      = sid_ff[IDX_W-1:0];
   assign sid_in_range = {1'b0, sid_ff} < SLOT_LIM;
   assign sid_ok       = sid_in_range ? active_ff[sid_idx] : 1'b0;
   assign too_short    = dur_ff < min_dur_ff;
   assign start_ok     = !too_short && free_found;

   // lowest free slot, lowest fired slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      fire_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
         if (fired_ff[i]) begin
            fire_idx = IDX_W'(i);
         end
      end
   end

   assign status.is_tick   = act_ff == ACT_TICK;
   assign status.fire_any  = |fired_ff;
   assign status.fire_last = (fired_ff & (fired_ff - SLOT_COUNT'(1))) == '0;

   always_comb begin
      active_in = active_ff;
      fired_in  = fired_ff;
      rem_in    = rem_ff;
      if (cmd.apply_tick) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            fired_in[i] = 1'b0;
            if (active_ff[i]) begin
               if (rem_ff[i] <= DUR_W'(1)) begin
                  rem_in[i]    = '0;
                  active_in[i] = 1'b0;
                  fired_in[i]  = 1'b1;
               end else begin
                  rem_in[i] = rem_ff[i] - DUR_W'(1);
               end
            end
         end
      end
      if (cmd.emit) begin
         fired_in[fire_idx] = 1'b0;
      end
      if (cmd.apply_op) begin
         if (act_ff == ACT_START && start_ok) begin
            active_in[free_idx] = 1'b1;
            rem_in[free_idx]    = dur_ff;
         end
         if (act_ff == ACT_CANCEL && sid_ok) begin
            active_in[sid_idx] = 1'b0;
         end
      end
   end

   always_comb begin
      kind_in = kind_ff;
      stat_in = stat_ff;
      slot_in = slot_ff;
      remo_in = remo_ff;
      any_in  = any_ff;
      last_in = last_ff;
      if (cmd.apply_op) begin
         remo_in = '0;
         any_in  = |active_in;
         last_in = 1'b1;
         unique case (act_ff)
            ACT_START: begin
               kind_in = KIND_START;
               stat_in = too_short ? STAT_SHORT : (free_found ? STAT_OK : STAT_NOFREE);
               slot_in = start_ok ? SLOT_W'(free_idx) : '0;
            end
            ACT_CANCEL: begin
               kind_in = KIND_CANCEL;
               stat_in = sid_ok ? STAT_OK : STAT_INVALID;
               slot_in = sid_ff;
            end
            ACT_QUERY: begin
               kind_in = KIND_REMAIN;
               stat_in = sid_ok ? STAT_OK : STAT_INVALID;
               slot_in = sid_ff;
               remo_in = sid_ok ? rem_ff[sid_idx] : '0;
            end
            default: begin
               kind_in = KIND_EXPIRY;
               stat_in = STAT_OK;
               slot_in = '0;
            end
         endcase
      end else if (cmd.emit) begin
         kind_in = KIND_EXPIRY;
         stat_in = STAT_OK;
         slot_in = SLOT_W'(fire_idx);
         remo_in = '0;
         any_in  = |active_ff;
         last_in = status.fire_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff <= MIN_DUR_RESET;
         active_ff  <= '0;
         fired_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            min_dur_ff <= csr_wr_data;
         end
         active_ff <= active_in;
         fired_ff  <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         dur_ff <= req_duration;
         sid_ff <= req_slot_id;
      end
      rem_ff  <= rem_in;
      kind_ff <= kind_in;
      stat_ff <= stat_in;
      slot_ff <= slot_in;
      remo_ff <= remo_in;
      any_ff  <= any_in;
      last_ff <= last_in;
   end

   assign rsp_kind       = kind_ff;
   assign rsp_status     = stat_ff;
   assign rsp_slot_out   = slot_ff;
   assign rsp_remaining  = remo_ff;
   assign rsp_any_active = any_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== hdl/msot_checker.sv =====
`include "assert_macros.svh"

module msot_checker import msot_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot_out,
   input logic [DUR_W-1:0]    rsp_remaining,
   input logic                rsp_last
);

   `MSOT_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)
   `MSOT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot_out) && $stable(rsp_last))
   `MSOT_ASSERT(a_reply_is_last, clock, reset, rsp_valid && rsp_kind != KIND_EXPIRY |-> rsp_last)
   `MSOT_ASSERT(a_expiry_clean, clock, reset, rsp_valid && rsp_kind == KIND_EXPIRY |-> rsp_status == STAT_OK && rsp_remaining == '0)
   `MSOT_ASSERT(a_refused_slot0, clock, reset, rsp_valid && rsp_kind == KIND_START && rsp_status != STAT_OK |-> rsp_slot_out == '0)

endmodule

bind multi_slot_oneshot_timer msot_checker u_msot_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_status    (rsp_chan.status),
   .rsp_slot_out  (rsp_chan.slot_out),
   .rsp_remaining (rsp_chan.remaining),
   .rsp_last      (rsp_chan.last)
);

// ===== tb/multi_slot_oneshot_timer_test.sv =====
module multi_slot_oneshot_timer_test;
   import msot_pkg::*;

   localparam int SLOTS = (DEF_NUM_SLOTS > MAX_SLOTS) ? MAX_SLOTS :
                          ((DEF_NUM_SLOTS < 1) ? 1 : DEF_NUM_SLOTS);
   localparam int HOLD_CYCLES    = 90;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [DUR_W-1:0]    remaining;
      logic                any_active;
      logic                last;
   } timer_word_type;

   class timer_scoreboard_type;
      logic [DUR_W-1:0] min_dur;
      logic [DUR_W-1:0] count_left [SLOTS];
      bit               running [SLOTS];
      timer_word_type   expected_words [$];
      int               errors;

      function new();
         min_dur = MIN_DUR_RESET;
         foreach (count_left[i]) begin
            count_left[i] = '0;
            running[i]    = 1'b0;
         end
         errors = 0;
      endfunction

      function bit any_running();
         foreach (running[i])
            if (running[i])
               return 1'b1;
         return 1'b0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function logic [SLOT_W-1:0] pick_running_slot();
         int live [$];
         foreach (running[i])
            if (running[i])
               live.push_back(i);
         if (live.size() == 0)
            return SLOT_W'($urandom_range(0, 15));
         return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
      endfunction

      // any_active reflects the state after the word's own update
      function void push_word(input logic [KIND_W-1:0] kind,
                              input logic [STATUS_W-1:0] status,
                              input logic [SLOT_W-1:0] slot,
                              input logic [DUR_W-1:0] remaining,
                              input logic last);
         timer_word_type w;
         w.kind       = kind;
         w.status     = status;
         w.slot       = slot;
         w.remaining  = remaining;
         w.any_active = any_running();
         w.last       = last;
         expected_words.push_back(w);
      endfunction

      function void apply_request(input logic [ACTION_W-1:0] action,
                                  input logic [DUR_W-1:0] duration,
                                  input logic [SLOT_W-1:0] sid);
         bit fired [SLOTS];
         int free_slot;
         int last_fired;
         bit ok;
         case (action)
            ACT_TICK: begin
               last_fired = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  fired[i] = 1'b0;
                  if (running[i]) begin
                     if (count_left[i] <= 1) begin
                        count_left[i] = '0;
                        running[i]    = 1'b0;
                        fired[i]      = 1'b1;
                        last_fired    = i;
                     end else begin
                        count_left[i] = count_left[i] - 1;
                     end
                  end
               end
               for (int i = 0; i < SLOTS; i++)
                  if (fired[i])
                     push_word(KIND_EXPIRY, STAT_OK, SLOT_W'(i), '0, i == last_fired);
            end
            ACT_START: begin
               if (duration < min_dur) begin
                  push_word(KIND_START, STAT_SHORT, '0, '0, 1'b1);
               end else begin
                  free_slot = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (!running[i] && free_slot < 0)
                        free_slot = i;
                  if (free_slot < 0) begin
                     push_word(KIND_START, STAT_NOFREE, '0, '0, 1'b1);
                  end else begin
                     running[free_slot]    = 1'b1;
                     count_left[free_slot] = duration;
                     push_word(KIND_START, STAT_OK, SLOT_W'(free_slot), '0, 1'b1);
                  end
               end
            end
            default: begin
               ok = 1'b0;
               if (int'(sid) < SLOTS)
                  ok = running[sid];
               if (action == ACT_CANCEL) begin
                  if (ok) begin
                     running[sid]    = 1'b0;
                     count_left[sid] = '0;
                  end
                  push_word(KIND_CANCEL, ok ? STAT_OK : STAT_INVALID, sid, '0, 1'b1);
               end else begin
                  push_word(KIND_REMAIN, ok ? STAT_OK : STAT_INVALID, sid,
                            ok ? count_left[sid] : '0, 1'b1);
               end
            end
         endcase
      endfunction

      task report_mismatch(input string what, input logic [DUR_W-1:0] got,
                           input logic [DUR_W-1:0] want);
         $display("mismatch on %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_reply(input timer_word_type got);
         timer_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, slot", got.slot, '0);
            return;
         end
         want = expected_words.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", got.kind, want.kind);
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
         if (got.slot !== want.slot)
            report_mismatch("slot_out", got.slot, want.slot);
         if (got.remaining !== want.remaining)
            report_mismatch("remaining", got.remaining, want.remaining);
         if (got.any_active !== want.any_active)
            report_mismatch("any_active", got.any_active, want.any_active);
         if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [DUR_W-1:0] csr_wr_data;

   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   bit hold_off_req = 1'b0;
   int quiet_cycles = 0;

   timer_scoreboard_type sb;

   msot_req_if req_if ();
   msot_rsp_if rsp_if ();

   multi_slot_oneshot_timer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   always #6 clock = ~clock;

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      timer_word_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind       = rsp_if.kind;
            got.status     = rsp_if.status;
            got.slot       = rsp_if.slot_out;
            got.remaining  = rsp_if.remaining;
            got.any_active = rsp_if.any_active;
            got.last       = rsp_if.last;
            sb.check_reply(got);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [ACTION_W-1:0] act, input logic [DUR_W-1:0] dur,
                            input logic [SLOT_W-1:0] sid);
      if (send_idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.action   <= act;
      req_if.duration <= dur;
      req_if.slot_id  <= sid;
      do
         @(posedge clock);
      while (!req_if.ready);
      sb.apply_request(act, dur, sid);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_min_duration(input logic [DUR_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.min_dur = value;
   endtask

   function automatic logic [DUR_W-1:0] pick_duration();
      logic [DUR_W-1:0] d;
      case ($urandom_range(0, 9))
         0: d = $urandom();
         1: d = (sb.min_dur == 0) ? '0 : sb.min_dur - 1;
         default: begin
            d = sb.min_dur + $urandom_range(0, 12);
            if (d < sb.min_dur)
               d = '1;
         end
      endcase
      return d;
   endfunction

   task automatic send_random_item();
      logic [ACTION_W-1:0] act;
      logic [DUR_W-1:0]    dur;
      logic [SLOT_W-1:0]   sid;
      int                  pick;
      pick = $urandom_range(0, 99);
      dur  = $urandom();
      sid  = $urandom_range(0, 15);
      if (pick < 35) begin
         act = ACT_TICK;
      end else if (pick < 70) begin
         act = ACT_START;
         dur = pick_duration();
      end else begin
         act = (pick < 85) ? ACT_CANCEL : ACT_QUERY;
         if ($urandom_range(0, 9) < 7)
            sid = sb.pick_running_slot();
      end
      send_word(act, dur, sid);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_random_item();
   endtask

   initial begin
      sb = new();
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_if.valid    = 1'b0;
      req_if.action   = ACT_TICK;
      req_if.duration = '0;
      req_if.slot_id  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(ACT_START, '0, 4'd0);
      send_word(ACT_START, '1, 4'd15);
      send_word(ACT_QUERY, '0, 4'd0);
      send_word(ACT_QUERY, '1, 4'd15);
      send_word(ACT_CANCEL, '0, 4'd15);
      send_word(ACT_CANCEL, '1, 4'd0);
      for (int i = 0; i < SLOTS; i++)
         send_word(ACT_START, 32'd1, SLOT_W'(i));
      send_word(ACT_START, 32'd1, 4'd0);
      send_word(ACT_TICK, '1, 4'd15);
      send_word(ACT_TICK, '0, 4'd0);

      // zero-length timer expires on the next tick
      write_min_duration('0);
      send_word(ACT_START, '0, 4'd0);
      send_word(ACT_QUERY, '0, 4'd0);
      send_word(ACT_TICK, '0, 4'd0);

      write_min_duration('1);
      send_word(ACT_START, 32'hFFFF_FFFE, 4'd0);
      send_word(ACT_START, '1, 4'd0);
      send_word(ACT_CANCEL, '0, 4'd0);

      write_min_duration(MIN_DUR_RESET);
      run_random(25);

      // long output stall with back-to-back input, then a full drain
      hold_off_req = 1'b1;
      send_idle_on = 1'b0;
      run_random(20);
      send_idle_on = 1'b1;
      wait_drained();
      run_random(15);

      write_min_duration('0);
      run_random(45);
      write_min_duration(32'hFFFF_FFF0);
      run_random(15);
      write_min_duration(32'd5);
      run_random(20);
      write_min_duration(32'd3);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      run_random(40);

      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== multi_slot_oneshot_timer.f =====
+incdir+hdl
hdl/msot_pkg.sv
hdl/msot_req_if.sv
hdl/msot_rsp_if.sv
hdl/msot_ctrl.sv
hdl/msot_datapath.sv
hdl/multi_slot_oneshot_timer.sv
hdl/msot_checker.sv
tb/multi_slot_oneshot_timer_test.sv
